// ===== rtl/bit_parallel_edit_distance_macros.svh =====
// Assertion macros shared by the edit distance RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef BIT_PARALLEL_EDIT_DISTANCE_MACROS_SVH
`define BIT_PARALLEL_EDIT_DISTANCE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define BPED_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is asserted.
`define BPED_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define BPED_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define BPED_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/bped_pkg.sv =====
// Shared constants and types for the bit-parallel edit distance block.
// No dependencies; used by the mask table and the top level.
package bped_pkg;

    localparam int CMD_W   = 2;
    localparam int SYM_W   = 8;
    localparam int POS_W   = 6;
    localparam int LEN_W   = 7;
    localparam int SCORE_W = 16;

    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PROCESS = 2'd2;

    localparam logic [SCORE_W-1:0] SCORE_MAX = 16'hFFFF;

    // Register index of pattern_length on the configuration port.
    localparam logic REG_PATTERN_LENGTH = 1'b0;

    // Control from the pipeline to the match-mask table.
    typedef struct packed {
        logic             rd_en;    // issue a table read for a newly accepted request
        logic [SYM_W-1:0] rd_sym;   // symbol of that request
        logic             clear;    // wipe every mask at this edge
        logic             set_en;   // OR a pattern bit into the entry read last
        logic [POS_W-1:0] set_pos;  // pattern position of that bit
    } tbl_ctrl_t;

endpackage

// ===== rtl/bped_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bped_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bped_mask_table.sv =====
// Match-mask table: RAM of per-symbol masks, valid bits per entry for a clear with no
// sweep, write forwarding for back-to-back updates. Depends on bped_pkg, bped_ram.
`include "bit_parallel_edit_distance_macros.svh"

module bped_mask_table #(
    parameter int PATTERN_BITS  = 64,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bped_pkg::tbl_ctrl_t    ctrl,
    output logic [PATTERN_BITS-1:0] eq_mask
);

    localparam int ADDR_W = $clog2(ALPHABET_SIZE);

    logic [ADDR_W-1:0]        addr_reg;
    logic                     in_range_reg;
    logic [ALPHABET_SIZE-1:0] valid_reg;
    logic [ALPHABET_SIZE-1:0] valid_next;
    logic                     fwd_vld_reg;
    logic [ADDR_W-1:0]        fwd_addr_reg;
    logic [PATTERN_BITS-1:0]  fwd_data_reg;

    logic [PATTERN_BITS-1:0]  ram_rdata;
    logic [PATTERN_BITS-1:0]  stored;
    logic                     rd_in_range;
    logic                     pos_ok;
    logic                     wr_en;
    logic [PATTERN_BITS-1:0]  wr_data;

    assign rd_in_range = ({1'b0, ctrl.rd_sym} < (bped_pkg::SYM_W + 1)'(ALPHABET_SIZE));
    assign pos_ok      = ({1'b0, ctrl.set_pos} < (bped_pkg::POS_W + 1)'(PATTERN_BITS));

    // The entry written at the edge that issued this read is not yet in the RAM output.
    assign stored  = (fwd_vld_reg && (fwd_addr_reg == addr_reg)) ? fwd_data_reg : ram_rdata;
    assign eq_mask = (in_range_reg && valid_reg[addr_reg]) ? stored : '0;

    assign wr_en   = ctrl.set_en && in_range_reg && pos_ok;
    assign wr_data = eq_mask | (PATTERN_BITS'(1) << ctrl.set_pos);

    always_comb begin
        valid_next = valid_reg;
        if (ctrl.clear) begin
            valid_next = '0;
        end else if (wr_en) begin
            valid_next[addr_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            fwd_vld_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (wr_en) begin
                fwd_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            addr_reg     <= ADDR_W'(ctrl.rd_sym);
            in_range_reg <= rd_in_range;
        end
        if (wr_en) begin
            fwd_addr_reg <= addr_reg;
            fwd_data_reg <= wr_data;
        end
    end

    bped_ram #(
        .WIDTH (PATTERN_BITS),
        .DEPTH (ALPHABET_SIZE)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (addr_reg),
        .wdata (wr_data),
        .re    (ctrl.rd_en),
        .raddr (ADDR_W'(ctrl.rd_sym)),
        .rdata (ram_rdata)
    );

    `BPED_ASSERT_NEXT(a_clear_empties, aclk, aresetn, ctrl.clear, valid_reg == '0)
    `BPED_ASSERT_NEXT(a_set_marks_valid, aclk, aresetn, wr_en, valid_reg[$past(addr_reg)])

endmodule

// ===== rtl/bit_parallel_edit_distance.sv =====
// Top level of the bit-parallel edit distance engine.
// Depends on bped_pkg, bped_mask_table (which holds bped_ram) and the macros header.
//
// This block computes the Levenshtein distance between a loaded pattern of up to
// PATTERN_BITS symbols and a streamed text, one text symbol per request, using the
// bit-vector recurrence of Myers. Requests carry a command in s_tuser: clear the
// match-mask table, load one pattern symbol at a position, or process one text
// symbol (optionally flagged as the first of a text). Only process requests return
// a result, the distance so far, which saturates at 65535. The block sustains one
// request per clock cycle for every command mix while the result channel keeps up:
// the symbol addresses the single-read-port mask RAM at the accepting edge, and the
// registered mask is used from stage 1, either for the read-modify-write of a load
// or for the recurrence, whose critical path is a single PATTERN_BITS-wide add. A
// result is registered onto m_tdata when its request leaves stage 1, so it is never
// offered at the edge that accepted its request. A process request in stage 1 waits
// only while the output register holds a result that the receiver has not yet
// taken; loads and clears there never wait, but a new request waits behind a
// stalled process. A clear takes effect at once through per-entry valid bits, so
// there is no sweep over the table after reset or a clear. pattern_length must only
// be written while no request is in flight.
`include "bit_parallel_edit_distance_macros.svh"

module bit_parallel_edit_distance #(
    parameter int PATTERN_BITS  = 64,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] symbol, [13:8] position, [15:14] zero
    input  logic [2:0]  s_tuser,   // [1:0] cmd, [2] text_first
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] distance
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (PATTERN_BITS > 1) ? $clog2(PATTERN_BITS) : 1;
    localparam int LEN_W = bped_pkg::LEN_W;
    localparam int SC_W  = bped_pkg::SCORE_W;

    // Configuration register. Only word index 0 exists; writes elsewhere are dropped.
    logic [LEN_W-1:0] pattern_length_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == bped_pkg::REG_PATTERN_LENGTH);
    assign prdata    = (paddr[2] == bped_pkg::REG_PATTERN_LENGTH) ?
                       {{(32 - LEN_W){1'b0}}, pattern_length_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= LEN_W'(1);
        end else if (cfg_write) begin
            pattern_length_reg <= pwdata[LEN_W-1:0];
        end
    end

    // Stage 1 holds the request whose table read is in flight.
    logic                          s1_valid_reg, s1_valid_next;
    logic [bped_pkg::CMD_W-1:0]    s1_cmd_reg;
    logic [bped_pkg::POS_W-1:0]    s1_pos_reg;
    logic                          s1_first_reg;

    // Recurrence state.
    logic [PATTERN_BITS-1:0] pv_reg, pv_next;
    logic [PATTERN_BITS-1:0] mv_reg, mv_next;
    logic [SC_W-1:0]         score_reg, score_next;

    // Output register.
    logic            m_valid_reg, m_valid_next;
    logic [SC_W-1:0] m_data_reg;

    logic s_fire;
    logic out_free;
    logic s1_advance;
    logic s1_fire_proc;

    bped_pkg::tbl_ctrl_t     tbl_ctrl;
    logic [PATTERN_BITS-1:0] eq_mask;

    // A load or clear never waits; a process waits only for the output register.
    assign out_free     = !m_valid_reg || m_tready;
    assign s1_advance   = s1_valid_reg && ((s1_cmd_reg != bped_pkg::CMD_PROCESS) || out_free);
    assign s1_fire_proc = s1_advance && (s1_cmd_reg == bped_pkg::CMD_PROCESS);
    assign s_tready     = !s1_valid_reg || s1_advance;
    assign s_fire       = s_tvalid && s_tready;

    always_comb begin
        tbl_ctrl.rd_en   = s_fire;
        tbl_ctrl.rd_sym  = s_tdata[7:0];
        tbl_ctrl.clear   = s1_advance && (s1_cmd_reg == bped_pkg::CMD_CLEAR);
        tbl_ctrl.set_en  = s1_advance && (s1_cmd_reg == bped_pkg::CMD_LOAD);
        tbl_ctrl.set_pos = s1_pos_reg;
    end

    bped_mask_table #(
        .PATTERN_BITS  (PATTERN_BITS),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_mask_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (tbl_ctrl),
        .eq_mask (eq_mask)
    );

    // Effective pattern length is clamped to the range 1..PATTERN_BITS.
    logic [LEN_W-1:0] eff_len;
    logic [IDX_W-1:0] last_idx;

    always_comb begin
        if (pattern_length_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (pattern_length_reg > LEN_W'(PATTERN_BITS)) begin
            eff_len = LEN_W'(PATTERN_BITS);
        end else begin
            eff_len = pattern_length_reg;
        end
    end

    assign last_idx = IDX_W'(eff_len - LEN_W'(1));

    // One column step of the recurrence. A first symbol starts from fresh vectors.
    logic [PATTERN_BITS-1:0] pv_in, mv_in;
    logic [SC_W-1:0]         score_in;
    logic [PATTERN_BITS-1:0] xv, xh, ph, mh, ph_sh;

    assign pv_in    = s1_first_reg ? '1 : pv_reg;
    assign mv_in    = s1_first_reg ? '0 : mv_reg;
    assign score_in = s1_first_reg ? {{(SC_W - LEN_W){1'b0}}, eff_len} : score_reg;

    assign xv    = eq_mask | mv_in;
    assign xh    = (((eq_mask & pv_in) + pv_in) ^ pv_in) | eq_mask;
    assign ph    = mv_in | ~(xh | pv_in);
    assign mh    = pv_in & xh;
    assign ph_sh = (ph << 1) | PATTERN_BITS'(1);

    always_comb begin
        pv_next    = pv_reg;
        mv_next    = mv_reg;
        score_next = score_reg;
        if (s1_fire_proc) begin
            pv_next    = (mh << 1) | ~(xv | ph_sh);
            mv_next    = ph_sh & xv;
            score_next = score_in;
            // A horizontal delta at the last row moves the score by one.
            if (ph[last_idx]) begin
                if (score_in != bped_pkg::SCORE_MAX) begin
                    score_next = score_in + SC_W'(1);
                end
            end else if (mh[last_idx]) begin
                if (score_in != '0) begin
                    score_next = score_in - SC_W'(1);
                end
            end
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_fire) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (s1_fire_proc) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            pv_reg       <= '1;
            mv_reg       <= '0;
            score_reg    <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            pv_reg       <= pv_next;
            mv_reg       <= mv_next;
            score_reg    <= score_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_cmd_reg   <= s_tuser[1:0];
            s1_first_reg <= s_tuser[2];
            s1_pos_reg   <= s_tdata[13:8];
        end
        if (s1_fire_proc) begin
            m_data_reg <= score_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `BPED_ASSERT_NEXT(a_proc_gives_result, aclk, aresetn, s1_fire_proc, m_valid_reg)
    `BPED_ASSERT_IMPL(a_stall_only_on_output, aclk, aresetn, !s_tready,
                      s1_valid_reg && m_valid_reg && !m_tready)

endmodule

// ===== dv/bit_parallel_edit_distance_check.sv =====
`timescale 1ns / 1ps
// Checker for bit_parallel_edit_distance: watches the request, result and
// configuration ports, predicts every distance and compares it on arrival.
// Depends on bped_pkg only.
module bit_parallel_edit_distance_check #(
    parameter int PATTERN_BITS  = 64,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] symbol, [13:8] position, [15:14] zero
    input  logic [2:0]  s_tuser,   // [1:0] cmd, [2] text_first
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [15:0] distance
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    localparam logic [2:0] LENGTH_ADDR = {bped_pkg::REG_PATTERN_LENGTH, 2'b00};

    logic [PATTERN_BITS-1:0]          symbol_masks [ALPHABET_SIZE];
    logic [PATTERN_BITS-1:0]          pos_delta;
    logic [PATTERN_BITS-1:0]          neg_delta;
    logic [bped_pkg::SCORE_W-1:0]     score;
    logic [bped_pkg::LEN_W-1:0]       length_reg;
    logic [bped_pkg::SCORE_W-1:0]     expected_distances [$];
    logic [bped_pkg::SCORE_W-1:0]     want_distance;

    // Applies one accepted request to the shadow state and queues the
    // distance it produces, if any.
    task automatic step_edit_distance(input logic [bped_pkg::CMD_W-1:0] cmd,
                                      input logic [bped_pkg::SYM_W-1:0] sym,
                                      input logic [bped_pkg::POS_W-1:0] pos,
                                      input logic first);
        logic [PATTERN_BITS-1:0] one;
        logic [PATTERN_BITS-1:0] last;
        logic [PATTERN_BITS-1:0] eq, pv, mv, xv, xh, ph, mh;
        int unsigned len;
        int i;
        one = PATTERN_BITS'(1);
        case (cmd)
            bped_pkg::CMD_CLEAR: begin
                for (i = 0; i < ALPHABET_SIZE; i++) symbol_masks[i] = '0;
            end
            bped_pkg::CMD_LOAD: begin
                if (sym < ALPHABET_SIZE && pos < PATTERN_BITS)
                    symbol_masks[sym] = symbol_masks[sym] | (one << pos);
            end
            bped_pkg::CMD_PROCESS: begin
                // A length of zero acts as one, anything past the vector width as the width.
                if (length_reg == 0) len = 1;
                else if (length_reg > PATTERN_BITS) len = PATTERN_BITS;
                else len = {{(32 - bped_pkg::LEN_W){1'b0}}, length_reg};
                last = one << (len - 1);
                if (first) begin
                    pos_delta = '1;
                    neg_delta = '0;
                    score     = bped_pkg::SCORE_W'(len);
                end
                pv = pos_delta;
                mv = neg_delta;
                eq = (sym < ALPHABET_SIZE) ? symbol_masks[sym] : '0;
                xv = eq | mv;
                xh = (((eq & pv) + pv) ^ pv) | eq;
                ph = mv | ~(xh | pv);
                mh = pv & xh;
                if ((ph & last) != 0) begin
                    if (score != bped_pkg::SCORE_MAX) score = score + 1'b1;
                end else if ((mh & last) != 0) begin
                    if (score != 0) score = score - 1'b1;
                end
                ph = (ph << 1) | one;
                pos_delta = (mh << 1) | ~(xv | ph);
                neg_delta = ph & xv;
                expected_distances.push_back(score);
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < ALPHABET_SIZE; k++) symbol_masks[k] = '0;
            pos_delta  = '1;
            neg_delta  = '0;
            score      = '0;
            length_reg = bped_pkg::LEN_W'(1);
            expected_distances.delete();
        end else begin
            // A result is never offered at the edge that accepts its request, so
            // comparing before predicting this edge's request is safe.
            if (m_tvalid && m_tready) begin
                if (expected_distances.size() == 0) begin
                    fail_count = fail_count + 1;
                    $display("%0t: unexpected result: expected none, actual %0d",
                             $time, m_tdata);
                end else begin
                    want_distance = expected_distances.pop_front();
                    if (m_tdata !== want_distance) begin
                        fail_count = fail_count + 1;
                        $display("%0t: distance mismatch: expected %0d, actual %0d",
                                 $time, want_distance, m_tdata);
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr == LENGTH_ADDR)
                length_reg = pwdata[bped_pkg::LEN_W-1:0];
            if (s_tvalid && s_tready)
                step_edit_distance(s_tuser[1:0], s_tdata[7:0], s_tdata[13:8], s_tuser[2]);
        end
        pending = expected_distances.size();
    end

endmodule

// ===== dv/bit_parallel_edit_distance_test.sv =====
`timescale 1ns / 1ps
// Testbench top for bit_parallel_edit_distance: clock, reset, request and
// register stimulus, receiver stalls and the final verdict.
// Depends on bped_pkg, the block and bit_parallel_edit_distance_check.
module bit_parallel_edit_distance_test;

    // Far above what the whole run needs, even with the longest sender gaps
    // and receiver stalls.
    localparam int CYCLE_LIMIT       = 400_000;
    // Loads, clears and ignored commands give no result, so settle waits these
    // extra cycles to cover a request still in the pipeline.
    localparam int DRAIN_CYCLES      = 8;
    localparam int RANDOM_REQUESTS   = 1350;

    localparam logic [2:0] ADDR_PATTERN_LENGTH = {bped_pkg::REG_PATTERN_LENGTH, 2'b00};
    // An address with no register behind it; writes there must change nothing.
    localparam logic [2:0] ADDR_UNMAPPED       = 3'd4;
    // The one command code the block ignores.
    localparam logic [bped_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_BURSTY} rx_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [7:0] symbol, [13:8] position, [15:14] zero
    logic [2:0]  s_tuser;    // [1:0] cmd, [2] text_first
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;    // [15:0] distance
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int cycle_count;

    // Sender and receiver pacing.
    int       burst_left;
    bit       tx_steady;
    rx_mode_t rx_mode;
    int       rx_left;
    int       rx_hold;
    int       rx_phase;

    // Random sequence state: the pattern last loaded and a small alphabet
    // that keeps texts close to it.
    logic [bped_pkg::SYM_W-1:0] pattern_syms [64];
    logic [bped_pkg::SYM_W-1:0] alpha_base;
    int                         alpha_size;
    int                         requests_sent;

    bit_parallel_edit_distance u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    bit_parallel_edit_distance_check u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop in case a request or a result never completes its handshake.
    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The receiver changes its stall behavior at random among four modes:
    // always ready, a coin toss, a fixed duty cycle, or rare long stalls.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(40, 400);
        end else begin
            rx_left = rx_left - 1;
        end
        rx_phase = rx_phase + 1;
        case (rx_mode)
            RX_OPEN:     m_tready = 1'b1;
            RX_COIN:     m_tready = ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_tready = ((rx_phase % 7) < 4);
            default: begin
                if (rx_hold > 0) begin
                    m_tready = 1'b0;
                    rx_hold  = rx_hold - 1;
                end else begin
                    m_tready = 1'b1;
                    if ($urandom_range(0, 11) == 0) rx_hold = $urandom_range(3, 15);
                end
            end
        endcase
    end

    // Presents one request and returns at the falling edge after it was taken.
    // tvalid stays high on return so that back-to-back requests need no second
    // assignment in one step; a gap at the start of a burst lowers it.
    task automatic send_request(input logic [bped_pkg::CMD_W-1:0] cmd,
                                input logic [bped_pkg::SYM_W-1:0] sym,
                                input logic [bped_pkg::POS_W-1:0] pos,
                                input bit first);
        int gap;
        gap = 0;
        if (!tx_steady) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
            end
            burst_left = burst_left - 1;
        end
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {2'b00, pos, sym};
        s_tuser  = {first, cmd};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (cmd != CMD_UNUSED) requests_sent = requests_sent + 1;
    endtask

    // Stops the request stream and waits until the block is idle.
    task automatic settle();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        settle();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Only the low seven bits hold the length; the rest is sometimes noise.
    task automatic write_length(input int length);
        logic [31:0] noise;
        noise = $urandom_range(0, 1) ? ($urandom() & 32'hFFFF_FF80) : 32'h0;
        write_register(ADDR_PATTERN_LENGTH, noise | (length & 32'h7F));
    endtask

    // Mostly symbols from the current small alphabet, now and then any byte.
    function automatic logic [bped_pkg::SYM_W-1:0] pick_symbol();
        if ($urandom_range(0, 9) == 0) return bped_pkg::SYM_W'($urandom_range(0, 255));
        return alpha_base + bped_pkg::SYM_W'($urandom_range(0, alpha_size - 1));
    endfunction

    function automatic logic [bped_pkg::POS_W-1:0] any_position();
        return bped_pkg::POS_W'($urandom_range(0, 63));
    endfunction

    int random_start;
    int length;
    int eff_length;
    int text_count;
    int text_len;
    bit mutate;
    bit flagged;
    logic [bped_pkg::SYM_W-1:0] sym;

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // Directed part, starting from the reset length of one. A match on the
        // only pattern bit without the first flag must hold the zero score.
        send_request(bped_pkg::CMD_LOAD, 8'h41, 6'd0, 1'b0);
        send_request(bped_pkg::CMD_PROCESS, 8'h41, any_position(), 1'b0);
        send_request(bped_pkg::CMD_PROCESS, 8'h42, any_position(), 1'b0);
        send_request(CMD_UNUSED, 8'hFF, 6'd63, 1'b1);
        send_request(bped_pkg::CMD_PROCESS, 8'h41, 6'd0, 1'b1);

        // A length of zero behaves like one.
        write_length(0);
        send_request(bped_pkg::CMD_PROCESS, 8'h00, 6'd0, 1'b1);
        send_request(bped_pkg::CMD_PROCESS, 8'h41, 6'd0, 1'b0);

        // Nothing lives at the unmapped address.
        write_register(ADDR_UNMAPPED, 32'd5);
        send_request(bped_pkg::CMD_PROCESS, 8'h41, 6'd0, 1'b1);

        // After a clear no symbol matches.
        send_request(bped_pkg::CMD_CLEAR, 8'hFF, 6'd63, 1'b1);
        send_request(bped_pkg::CMD_PROCESS, 8'h41, 6'd0, 1'b1);

        // A length above the vector width behaves like the full width.
        write_length(127);
        send_request(bped_pkg::CMD_LOAD, 8'hFF, 6'd63, 1'b1);
        send_request(bped_pkg::CMD_LOAD, 8'h00, 6'd0, 1'b0);
        send_request(bped_pkg::CMD_LOAD, 8'hAA, 6'd21, 1'b0);
        send_request(bped_pkg::CMD_LOAD, 8'h55, 6'd42, 1'b1);
        send_request(bped_pkg::CMD_PROCESS, 8'hFF, 6'd63, 1'b1);
        send_request(bped_pkg::CMD_PROCESS, 8'h00, 6'd0, 1'b0);
        send_request(bped_pkg::CMD_PROCESS, 8'hAA, 6'd21, 1'b0);
        send_request(bped_pkg::CMD_PROCESS, 8'h55, 6'd42, 1'b0);
        send_request(CMD_UNUSED, 8'h00, 6'd0, 1'b0);

        write_length(64);
        send_request(bped_pkg::CMD_PROCESS, 8'hFF, 6'd0, 1'b1);
        send_request(bped_pkg::CMD_PROCESS, 8'h00, 6'd0, 1'b0);
        write_length(63);
        send_request(bped_pkg::CMD_PROCESS, 8'h00, 6'd0, 1'b1);
        send_request(bped_pkg::CMD_PROCESS, 8'hFF, 6'd0, 1'b0);

        // Random part. Each phase picks a length, loads a pattern after a
        // clear and runs a few texts against it. Most texts start with the
        // first flag and follow the pattern loosely; some skip the flag, and
        // stray loads, clears and ignored commands are mixed in as noise.
        random_start = requests_sent;
        while (requests_sent - random_start < RANDOM_REQUESTS) begin
            case ($urandom_range(0, 9))
                0:       length = 1;
                1:       length = 64;
                2:       length = 0;
                3:       length = 127;
                4:       length = $urandom_range(65, 126);
                5:       length = $urandom_range(13, 63);
                default: length = $urandom_range(1, 12);
            endcase
            eff_length = (length < 1) ? 1 : (length > 64) ? 64 : length;
            write_length(length);
            tx_steady  = ($urandom_range(0, 3) == 0);
            alpha_base = bped_pkg::SYM_W'($urandom_range(0, 255));
            alpha_size = $urandom_range(2, 6);

            send_request(bped_pkg::CMD_CLEAR, bped_pkg::SYM_W'($urandom()), any_position(),
                         1'($urandom_range(0, 1)));
            for (int i = 0; i < eff_length; i++) begin
                pattern_syms[i] = pick_symbol();
                send_request(bped_pkg::CMD_LOAD, pattern_syms[i], bped_pkg::POS_W'(i),
                             1'($urandom_range(0, 1)));
                if ($urandom_range(0, 9) == 0)
                    send_request(bped_pkg::CMD_LOAD, bped_pkg::SYM_W'($urandom()),
                                 any_position(), 1'($urandom_range(0, 1)));
            end

            text_count = $urandom_range(1, 4);
            for (int t = 0; t < text_count; t++) begin
                text_len = $urandom_range(1, (eff_length + 8 > 40) ? 40 : eff_length + 8);
                mutate   = ($urandom_range(0, 2) != 0);
                flagged  = ($urandom_range(0, 7) != 0);
                for (int j = 0; j < text_len; j++) begin
                    if (mutate && j < eff_length && $urandom_range(0, 3) != 0)
                        sym = pattern_syms[j];
                    else
                        sym = pick_symbol();
                    send_request(bped_pkg::CMD_PROCESS, sym, any_position(), flagged && j == 0);
                    if ($urandom_range(0, 29) == 0)
                        send_request(CMD_UNUSED, bped_pkg::SYM_W'($urandom()), any_position(),
                                     1'($urandom_range(0, 1)));
                    if ($urandom_range(0, 79) == 0)
                        send_request(bped_pkg::CMD_CLEAR, bped_pkg::SYM_W'($urandom()),
                                     any_position(), 1'($urandom_range(0, 1)));
                end
            end
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
